// ===== rtl/twsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package twsm_pkg;

    localparam int CoordBits = 13;
    localparam int SumBits   = CoordBits + 14;
    localparam int NumBits   = CoordBits + 12;
    localparam int DenBits   = CoordBits + 2;
    localparam int QuotBits  = 8;
    localparam int CfgIdxBits = 3;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_WINDOW_WIDTH  = 3'd0,
        CFG_WINDOW_HEIGHT = 3'd1,
        CFG_LETTERBOX_ON  = 3'd2,
        CFG_ROTATION      = 3'd3,
        CFG_GAP_PIXELS    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CoordBits-1:0] win_x;
        logic [CoordBits-1:0] win_y;
    } t_in_word;

    typedef struct packed {
        logic       on_screen;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
    } t_out_word;

    typedef struct packed {
        logic [CoordBits-1:0] window_width;
        logic [CoordBits-1:0] window_height;
        logic                 letterbox_on;
        logic [1:0]           rotation;
        logic [CoordBits-1:0] gap_pixels;
    } t_cfg;

    typedef struct packed {
        logic               fail;
        logic               neg_x;
        logic [NumBits-1:0] num_x;
        logic [DenBits-1:0] den_x;
        logic               neg_y;
        logic [NumBits-1:0] num_y;
        logic [DenBits-1:0] den_y;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/touch_window_to_screen_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Signals                              Word
// in       input      i_in_valid / o_in_ready / i_in       t_in_word
// out      output     o_out_valid / i_out_ready / o_out    t_out_word
// cfg      input      i_cfg_valid / o_cfg_ready            i_cfg_index, i_cfg_data
//
// One word is accepted per cycle and one result leaves per cycle while the output is not stalled.
// Each word passes the classify register, the two-entry queue,
// the overflow check, eight quotient-bit stages and the output register.
// Synchronous active-low reset clears all valid flags and loads the register defaults.
// A stalled output holds the divider pipeline; the queue absorbs the front meanwhile.

module touch_window_to_screen_mapper (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  twsm_pkg::t_in_word                   i_in,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output twsm_pkg::t_out_word                  o_out,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [twsm_pkg::CfgIdxBits-1:0]       i_cfg_index,
    input  wire [twsm_pkg::CoordBits-1:0]        i_cfg_data
);
    import twsm_pkg::*;

    t_cfg r_cfg;
    logic job_valid, job_ready, q_valid, q_ready;
    t_job job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_width  <= CoordBits'(256);
            r_cfg.window_height <= CoordBits'(384);
            r_cfg.letterbox_on  <= 1'b0;
            r_cfg.rotation      <= 2'd0;
            r_cfg.gap_pixels    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data;
                CFG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data;
                CFG_LETTERBOX_ON:  r_cfg.letterbox_on  <= i_cfg_data[0];
                CFG_ROTATION:      r_cfg.rotation      <= i_cfg_data[1:0];
                CFG_GAP_PIXELS:    r_cfg.gap_pixels    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    twsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    twsm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid),
        .o_push_ready (job_ready),
        .i_push       (job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_job)
    );

    twsm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.screen_y < 8'd192))
        else $error("screen row out of range");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.on_screen) |-> (o_out.screen_x == 8'd0 && o_out.screen_y == 8'd0))
        else $error("off-screen result carries a coordinate");

    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && !job_ready) |-> q_valid)
        else $error("queue refuses a word while empty");

endmodule

`default_nettype wire

// ===== rtl/twsm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twsm_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  twsm_pkg::t_in_word   i_in,
    input  twsm_pkg::t_cfg       i_cfg,
    output logic                 o_job_valid,
    input  wire                  i_job_ready,
    output twsm_pkg::t_job       o_job
);
    import twsm_pkg::*;

    localparam int PadBits = SumBits - CoordBits;

    logic signed [SumBits-1:0] w0, h0, x0, y0, g;
    logic signed [SumBits-1:0] w1, h1, x1, y1;
    logic signed [SumBits-1:0] w2, h2, x2, y2;
    logic signed [SumBits-1:0] y3, h3, d;
    logic signed [SumBits-1:0] nx, ny, dx, dy, ax, ay, sum_x, sum_y;
    logic                      reject, wide, fail;
    logic                      r_valid;
    t_job                      r_job, n_job;

    always_comb begin
        w0 = $signed({{PadBits{1'b0}}, i_cfg.window_width});
        h0 = $signed({{PadBits{1'b0}}, i_cfg.window_height});
        x0 = $signed({{PadBits{1'b0}}, i_in.win_x});
        y0 = $signed({{PadBits{1'b0}}, i_in.win_y});
        g  = $signed({{PadBits{1'b0}}, i_cfg.gap_pixels});

        if (i_cfg.rotation[0]) begin
            w1 = h0;
            h1 = w0;
            x1 = y0;
            y1 = w0 - x0;
        end else begin
            w1 = w0;
            h1 = h0;
            x1 = x0;
            y1 = y0;
        end
        if (i_cfg.rotation[1]) begin
            x2 = w1 - x1;
            y2 = h1 - y1;
        end else begin
            x2 = x1;
            y2 = y1;
        end
        w2 = w1;
        h2 = h1;

        reject = 1'b0;
        y3 = y2;
        h3 = h2;
        if (g > 0) begin
            if ((h2 - g < (y2 <<< 1)) && ((y2 <<< 1) < h2 + g)) begin
                reject = 1'b1;
            end else if ((y2 <<< 1) >= h2 + g) begin
                y3 = y2 - g;
            end
            h3 = h2 - g;
        end
        fail = reject || (w2 <= 0) || (h3 <= 0);

        d = (y3 <<< 1) - h3;
        wide = i_cfg.letterbox_on && ((w2 + (w2 <<< 1)) > (h3 <<< 1));
        if (wide) begin
            nx = ((x2 <<< 2) + (x2 <<< 1) - w2 - (w2 <<< 1) + (h3 <<< 1)) <<< 6;
            dx = h3;
            ny = (d <<< 7) + (d <<< 6);
            dy = h3;
        end else if (i_cfg.letterbox_on) begin
            nx = x2 <<< 8;
            dx = w2;
            ny = d <<< 7;
            dy = w2;
        end else begin
            nx = x2 <<< 8;
            dx = w2;
            ny = (d <<< 7) + (d <<< 6);
            dy = h3;
        end

        ax = nx[SumBits-1] ? -nx : nx;
        ay = ny[SumBits-1] ? -ny : ny;
        sum_x = (ax <<< 1) + dx;
        sum_y = (ay <<< 1) + dy;

        n_job.fail  = fail;
        n_job.neg_x = nx[SumBits-1];
        n_job.num_x = sum_x[NumBits-1:0];
        n_job.den_x = DenBits'(dx <<< 1);
        n_job.neg_y = ny[SumBits-1];
        n_job.num_y = sum_y[NumBits-1:0];
        n_job.den_y = DenBits'(dy <<< 1);
    end

    assign o_in_ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/twsm_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twsm_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    input  twsm_pkg::t_job  i_push,
    output logic            o_pop_valid,
    input  wire             i_pop_ready,
    output twsm_pkg::t_job  o_pop
);
    import twsm_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop        = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/twsm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twsm_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    input  twsm_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output twsm_pkg::t_out_word o_out
);
    import twsm_pkg::*;

    localparam int Steps = QuotBits;

    logic                r_v    [0:Steps];
    logic                r_fail [0:Steps];
    logic                r_ovx  [0:Steps];
    logic                r_ovy  [0:Steps];
    logic                r_negx [0:Steps];
    logic                r_negy [0:Steps];
    logic [NumBits-1:0]  r_remx [0:Steps];
    logic [NumBits-1:0]  r_remy [0:Steps];
    logic [DenBits-1:0]  r_denx [0:Steps];
    logic [DenBits-1:0]  r_deny [0:Steps];
    logic [QuotBits-1:0] r_qx   [0:Steps];
    logic [QuotBits-1:0] r_qy   [0:Steps];
    logic                r_out_v;
    t_out_word           r_out, n_out;
    logic                en;
    logic                ok_x, ok_y, on;

    assign en          = !r_out_v || i_out_ready;
    assign o_job_ready = en;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fail[0] <= i_job.fail;
            r_negx[0] <= i_job.neg_x;
            r_negy[0] <= i_job.neg_y;
            r_ovx[0]  <= i_job.num_x >= NumBits'({i_job.den_x, 8'd0});
            r_ovy[0]  <= i_job.num_y >= NumBits'({i_job.den_y, 8'd0});
            r_remx[0] <= i_job.num_x;
            r_remy[0] <= i_job.num_y;
            r_denx[0] <= i_job.den_x;
            r_deny[0] <= i_job.den_y;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= Steps; k++) begin : g_step
        logic [NumBits-1:0] trial_x, trial_y;
        logic               take_x, take_y;

        assign trial_x = NumBits'(r_denx[k-1]) << (Steps - k);
        assign trial_y = NumBits'(r_deny[k-1]) << (Steps - k);
        assign take_x  = r_remx[k-1] >= trial_x;
        assign take_y  = r_remy[k-1] >= trial_y;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_fail[k] <= r_fail[k-1];
                r_ovx[k]  <= r_ovx[k-1];
                r_ovy[k]  <= r_ovy[k-1];
                r_negx[k] <= r_negx[k-1];
                r_negy[k] <= r_negy[k-1];
                r_denx[k] <= r_denx[k-1];
                r_deny[k] <= r_deny[k-1];
                r_remx[k] <= take_x ? r_remx[k-1] - trial_x : r_remx[k-1];
                r_remy[k] <= take_y ? r_remy[k-1] - trial_y : r_remy[k-1];
                r_qx[k]   <= {r_qx[k-1][QuotBits-2:0], take_x};
                r_qy[k]   <= {r_qy[k-1][QuotBits-2:0], take_y};
            end
        end
    end

    always_comb begin
        ok_x = !r_ovx[Steps] && (!r_negx[Steps] || (r_qx[Steps] == '0));
        ok_y = !r_ovy[Steps] && (!r_negy[Steps] || (r_qy[Steps] == '0))
            && (r_qy[Steps] < 8'd192);
        on   = !r_fail[Steps] && ok_x && ok_y;
        n_out.on_screen = on;
        n_out.screen_x  = on ? r_qx[Steps] : 8'd0;
        n_out.screen_y  = on ? r_qy[Steps] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import twsm_pkg::*;

    class touch_scoreboard;
        logic [12:0] width;
        logic [12:0] height;
        logic        boxed;
        logic [1:0]  turn;
        logic [12:0] gap;
        t_out_word   pending[$];
        int          errors;

        function new();
            width = 256;
            height = 384;
            boxed = 0;
            turn = 0;
            gap = 0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [12:0] val);
            case (idx)
                CFG_WINDOW_WIDTH: width = val;
                CFG_WINDOW_HEIGHT: height = val;
                CFG_LETTERBOX_ON: boxed = val[0];
                CFG_ROTATION: turn = val[1:0];
                CFG_GAP_PIXELS: gap = val;
                default: ;
            endcase
        endfunction

        function longint round_div(longint n, longint d);
            if (n >= 0) return (2 * n + d) / (2 * d);
            return -((-2 * n + d) / (2 * d));
        endfunction

        function t_out_word map_point(t_in_word w);
            longint ww, hh, px, py, t, sx, sy, dd, gg;
            bit ok;
            t_out_word r;
            ww = width;
            hh = height;
            px = w.win_x;
            py = w.win_y;
            gg = gap;
            ok = 1;
            r = '0;
            if (turn[0]) begin
                t = ww; ww = hh; hh = t;
                t = px; px = py; py = hh - t;
            end
            if (turn[1]) begin
                px = ww - px;
                py = hh - py;
            end
            if (gg > 0) begin
                if (hh - gg < 2 * py && 2 * py < hh + gg) ok = 0;
                else if (2 * py >= hh + gg) py -= gg;
                hh -= gg;
            end
            if (!ok || ww <= 0 || hh <= 0) return r;
            dd = 2 * py - hh;
            if (boxed && 3 * ww > 2 * hh) begin
                sx = round_div(64 * (6 * px - 3 * ww + 2 * hh), hh);
                sy = round_div(192 * dd, hh);
            end else if (boxed) begin
                sx = round_div(256 * px, ww);
                sy = round_div(128 * dd, ww);
            end else begin
                sx = round_div(256 * px, ww);
                sy = round_div(192 * dd, hh);
            end
            if (sx < 0 || sx >= 256 || sy < 0 || sy >= 192) return r;
            r.on_screen = 1;
            r.screen_x = sx[7:0];
            r.screen_y = sy[7:0];
            return r;
        endfunction

        function void note_input(t_in_word w);
            pending.push_back(map_point(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.on_screen !== e.on_screen) begin
                $error("on_screen expected %0d actual %0d", e.on_screen, got.on_screen);
                errors++;
            end
            if (got.screen_x !== e.screen_x) begin
                $error("screen_x expected %0d actual %0d", e.screen_x, got.screen_x);
                errors++;
            end
            if (got.screen_y !== e.screen_y) begin
                $error("screen_y expected %0d actual %0d", e.screen_y, got.screen_y);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_in_valid = 0;
    t_in_word          i_in = '0;
    logic              i_out_ready = 0;
    logic              i_cfg_valid = 0;
    logic [2:0]        i_cfg_index = '0;
    logic [12:0]       i_cfg_data = '0;
    logic              o_in_ready, o_out_valid, o_cfg_ready;
    t_out_word         o_out;

    touch_scoreboard   sb;
    int                idle_pct = 7;
    bit                hold_out = 0;
    int                quiet = 0;

    touch_window_to_screen_mapper uut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (!hold_out && $urandom_range(99) >= idle_pct) i_out_ready <= 1;
        else i_out_ready <= 0;
    end

    always @(posedge i_clk) begin
        if (quiet > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_point(logic [12:0] px, logic [12:0] py);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= '{win_x: px, win_y: py};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(i_in);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [12:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [12:0] w, logic [12:0] h, logic b, logic [1:0] r,
                           logic [12:0] g);
        write_reg(CFG_WINDOW_WIDTH, w);
        write_reg(CFG_WINDOW_HEIGHT, h);
        write_reg(CFG_LETTERBOX_ON, {12'd0, b});
        write_reg(CFG_ROTATION, {11'd0, r});
        write_reg(CFG_GAP_PIXELS, g);
    endtask

    function automatic logic [12:0] near_span(logic [12:0] span);
        if ($urandom_range(9) == 0) return 13'($urandom_range(8191));
        return 13'($urandom_range(int'(span) + 2));
    endfunction

    task automatic random_points(int n);
        logic [12:0] w, h;
        w = sb.turn[0] ? sb.height : sb.width;
        h = sb.turn[0] ? sb.width : sb.height;
        repeat (n) send_point(near_span(sb.turn[0] ? h : w), near_span(sb.turn[0] ? w : h));
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_point(0, 0);
        send_point(0, 192);
        send_point(128, 288);
        send_point(255, 383);
        send_point(256, 384);
        send_point(8191, 8191);
        send_point(1, 191);
        drain();
        set_all(400, 500, 1, 0, 20);
        send_point(200, 240);
        send_point(200, 260);
        send_point(200, 499);
        send_point(0, 270);
        drain();
        set_all(8191, 8191, 1, 1, 8191);
        send_point(100, 100);
        drain();
        set_all(1, 1, 0, 3, 0);
        send_point(0, 1);
        send_point(1, 0);
        drain();
        set_all(300, 900, 1, 2, 0);
        send_point(150, 800);
        send_point(8191, 0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_all(256, 384, 0, 0, 0);
                1: set_all(8191, 8191, 1, 3, 8190);
                2: set_all(1, 1, 1, 1, 0);
                default: set_all(13'($urandom_range(1, 2000)), 13'($urandom_range(1, 2000)),
                                 1'($urandom_range(1)), 2'($urandom_range(3)),
                                 ($urandom_range(2) == 0) ? 13'd0 : 13'($urandom_range(300)));
            endcase
            if (ph == 4) begin
                idle_pct = 0;
                random_points(60);
                idle_pct = 7;
            end else if (ph == 6) begin
                fork
                    begin
                        hold_out = 1;
                        repeat (60) @(posedge i_clk);
                        hold_out = 0;
                    end
                    random_points(60);
                join
            end else begin
                random_points(60);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
